>>> sv/v3alu_pkg.sv
// shared types, constants and saturation helper for the vector alu
package v3alu_pkg;

    localparam int unsigned Q_SHIFT    = 16;
    localparam int unsigned WIDE_W     = 68;
    localparam int unsigned DIV_BITS   = 4;
    localparam int unsigned QUOT_W     = 48;
    localparam int unsigned DIV_STAGES = QUOT_W / DIV_BITS;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_DOT   = 4'd2,
        OP_CROSS = 4'd3,
        OP_SCALE = 4'd4,
        OP_DIV   = 4'd5,
        OP_LERP  = 4'd6,
        OP_DIST  = 4'd7,
        OP_EQUAL = 4'd8
    } op_t;

    localparam logic REG_USE_TOL = 1'b0;
    localparam logic REG_TOL     = 1'b1;

    localparam logic signed [WIDE_W-1:0] SAT_HI = {{(WIDE_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [WIDE_W-1:0] SAT_LO = {{(WIDE_W-31){1'b1}}, {31{1'b0}}};

    typedef struct packed {
        logic signed [31:0] val;
        logic               ov;
    } sat_t;

    // per-lane result handed to the merge stage
    typedef struct packed {
        logic signed [31:0]       vec;
        logic                     vov;
        logic signed [WIDE_W-1:0] prod;
        logic                     eq;
    } lane_out_t;

    function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
        sat_t r;
        if (v > SAT_HI) begin
            r.val = 32'sh7FFF_FFFF;
            r.ov  = 1'b1;
        end else if (v < SAT_LO) begin
            r.val = 32'sh8000_0000;
            r.ov  = 1'b1;
        end else begin
            r.val = v[31:0];
            r.ov  = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> sv/v3alu_lane.sv
// one component lane: multipliers, pipelined divider and per-component result
module v3alu_lane (
    input  logic                  aclk,
    input  logic                  en,
    input  v3alu_pkg::op_t        op,
    input  logic signed [31:0]    a_i,
    input  logic signed [31:0]    b_i,
    input  logic signed [31:0]    a_j,
    input  logic signed [31:0]    b_k,
    input  logic signed [31:0]    a_k,
    input  logic signed [31:0]    b_j,
    input  logic signed [31:0]    f,
    input  logic                  use_tol,
    input  logic [30:0]           tol,
    output v3alu_pkg::lane_out_t  lane_out
);
    import v3alu_pkg::*;

    typedef struct packed {
        logic [QUOT_W-1:0] num;
        logic [31:0]       rem;
        logic [QUOT_W-1:0] q;
        logic [31:0]       d;
        logic              neg;
    } div_t;

    typedef struct packed {
        op_t                      op;
        logic signed [31:0]       vec;
        logic                     vov;
        logic signed [WIDE_W-1:0] prod;
        logic                     eq;
    } side_t;

    // restoring division, a few quotient bits per stage
    function automatic div_t div_step(input div_t s);
        div_t        r;
        logic [32:0] trial;
        r = s;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial = {r.rem, r.num[QUOT_W-1]};
            r.num = {r.num[QUOT_W-2:0], 1'b0};
            if (trial >= {1'b0, r.d}) begin
                r.rem = 32'(trial - {1'b0, r.d});
                r.q   = {r.q[QUOT_W-2:0], 1'b1};
            end else begin
                r.rem = trial[31:0];
                r.q   = {r.q[QUOT_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic signed [32:0] sa, sb, diff, bma;
    logic [32:0]        absd;
    logic signed [32:0] m0a, m0b, m1a, m1b;
    logic [31:0]        amag, fmag;

    op_t                op0_reg;
    logic signed [65:0] p0_reg, p1_reg;
    logic signed [32:0] sum_reg;
    logic signed [31:0] a0_reg;
    logic               eq0_reg;

    div_t  div_reg [0:DIV_STAGES];
    side_t side_reg [1:DIV_STAGES];
    side_t side_next;
    sat_t  s_post, s_div;

    assign sa   = {a_i[31], a_i};
    assign sb   = {b_i[31], b_i};
    assign diff = sa - sb;
    assign bma  = sb - sa;
    assign absd = diff[32] ? 33'(-diff) : 33'(diff);
    assign amag = a_i[31] ? 32'(-a_i) : 32'(a_i);
    assign fmag = f[31] ? 32'(-f) : 32'(f);

    // operand selection for the two multipliers
    always_comb begin
        m0a = '0;
        m0b = '0;
        m1a = '0;
        m1b = '0;
        case (op)
            OP_DOT: begin
                m0a = sa;
                m0b = sb;
            end
            OP_CROSS: begin
                m0a = {a_j[31], a_j};
                m0b = {b_k[31], b_k};
                m1a = {a_k[31], a_k};
                m1b = {b_j[31], b_j};
            end
            OP_SCALE: begin
                m0a = sa;
                m0b = {f[31], f};
            end
            OP_LERP: begin
                m0a = bma;
                m0b = {f[31], f};
            end
            OP_DIST: begin
                m0a = diff;
                m0b = diff;
            end
            default: ;
        endcase
    end

    // per-component result for everything but division
    always_comb begin
        s_post = '0;
        case (op0_reg)
            OP_ADD, OP_SUB: s_post = sat32(WIDE_W'(sum_reg));
            OP_CROSS: s_post = sat32((WIDE_W'(p0_reg) - WIDE_W'(p1_reg)) >>> Q_SHIFT);
            OP_SCALE: s_post = sat32(WIDE_W'(p0_reg) >>> Q_SHIFT);
            OP_LERP:  s_post = sat32(WIDE_W'(a0_reg) + (WIDE_W'(p0_reg) >>> Q_SHIFT));
            default:  s_post = '0;
        endcase
        side_next.op   = op0_reg;
        side_next.vec  = s_post.val;
        side_next.vov  = s_post.ov;
        side_next.prod = WIDE_W'(p0_reg);
        side_next.eq   = eq0_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op0_reg        <= op;
            p0_reg         <= 66'(m0a) * 66'(m0b);
            p1_reg         <= 66'(m1a) * 66'(m1b);
            sum_reg        <= (op == OP_SUB) ? (sa - sb) : (sa + sb);
            a0_reg         <= a_i;
            eq0_reg        <= use_tol ? (absd < {2'b00, tol}) : (a_i == b_i);
            div_reg[0].num <= {amag, {Q_SHIFT{1'b0}}};
            div_reg[0].rem <= '0;
            div_reg[0].q   <= '0;
            div_reg[0].d   <= fmag;
            div_reg[0].neg <= a_i[31] ^ f[31];
            side_reg[1]    <= side_next;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                div_reg[s] <= div_step(div_reg[s-1]);
            end
            for (int s = 2; s <= DIV_STAGES; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // signed quotient, truncated toward zero
    always_comb begin
        s_div = sat32(div_reg[DIV_STAGES].neg ?
                      -$signed(WIDE_W'(div_reg[DIV_STAGES].q)) :
                      $signed(WIDE_W'(div_reg[DIV_STAGES].q)));
        lane_out.prod = side_reg[DIV_STAGES].prod;
        lane_out.eq   = side_reg[DIV_STAGES].eq;
        if (side_reg[DIV_STAGES].op == OP_DIV) begin
            lane_out.vec = s_div.val;
            lane_out.vov = s_div.ov;
        end else begin
            lane_out.vec = side_reg[DIV_STAGES].vec;
            lane_out.vov = side_reg[DIV_STAGES].vov;
        end
    end

endmodule

>>> sv/vec3_fixed_point_alu_unit.sv
// top level of the q16.16 three-component vector alu
//
//  port group     dir  handshake          contents
//  s_*            in   s_valid / s_ready  opcode, vectors a and b, factor
//  m_*            out  m_valid / m_ready  rx ry rz, rscalar, is_equal, status, overflow
//  apb            in   psel/penable       use_tolerance (0x0), tolerance (0x4)
//
// every item passes from acceptance to m_valid through one multiply stage,
// twelve divider stages of four quotient bits each, and the merge register
// one item is accepted per cycle; the whole pipeline advances together and
// halts only while a result sits in the output register with m_ready low
// aresetn is synchronous; it clears the valid bits and sets use_tolerance and tolerance to one
module vec3_fixed_point_alu_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_opcode,
    input  logic signed [31:0] s_ax,
    input  logic signed [31:0] s_ay,
    input  logic signed [31:0] s_az,
    input  logic signed [31:0] s_bx,
    input  logic signed [31:0] s_by,
    input  logic signed [31:0] s_bz,
    input  logic signed [31:0] s_factor,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_rx,
    output logic signed [31:0] m_ry,
    output logic signed [31:0] m_rz,
    output logic signed [31:0] m_rscalar,
    output logic               m_is_equal,
    output logic               m_status,
    output logic               m_overflow,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import v3alu_pkg::*;

    typedef struct packed {
        logic valid;
        op_t  op;
        logic dz;
    } ctl_t;

    // configuration registers
    logic        use_tol_reg;
    logic [30:0] tol_reg;

    // control travels beside the lanes
    ctl_t ctl_reg [0:DIV_STAGES];

    // output register
    logic               m_valid_reg;
    logic signed [31:0] rx_reg, ry_reg, rz_reg, rs_reg;
    logic               eq_reg, st_reg, ov_reg;

    logic               en;
    op_t                s_op;
    lane_out_t          lx, ly, lz;
    logic signed [31:0] rx_next, ry_next, rz_next, rs_next;
    logic               eq_next, st_next, ov_next;
    sat_t               s_sum;
    logic signed [WIDE_W-1:0] prod_sum;

    assign pready  = 1'b1;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign s_op    = op_t'(s_opcode);

    // apb register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_tol_reg <= 1'b1;
            tol_reg     <= 31'd1;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_USE_TOL: use_tol_reg <= pwdata[0];
                REG_TOL:     tol_reg     <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_USE_TOL: prdata = {31'd0, use_tol_reg};
            REG_TOL:     prdata = {1'b0, tol_reg};
            default:     prdata = '0;
        endcase
    end

    // lanes: x uses y*z - z*y for the cross term, and so on around
    v3alu_lane u_lane_x (
        .aclk(aclk), .en(en), .op(s_op),
        .a_i(s_ax), .b_i(s_bx), .a_j(s_ay), .b_k(s_bz), .a_k(s_az), .b_j(s_by),
        .f(s_factor), .use_tol(use_tol_reg), .tol(tol_reg), .lane_out(lx)
    );

    v3alu_lane u_lane_y (
        .aclk(aclk), .en(en), .op(s_op),
        .a_i(s_ay), .b_i(s_by), .a_j(s_az), .b_k(s_bx), .a_k(s_ax), .b_j(s_bz),
        .f(s_factor), .use_tol(use_tol_reg), .tol(tol_reg), .lane_out(ly)
    );

    v3alu_lane u_lane_z (
        .aclk(aclk), .en(en), .op(s_op),
        .a_i(s_az), .b_i(s_bz), .a_j(s_ax), .b_k(s_by), .a_k(s_ay), .b_j(s_bx),
        .f(s_factor), .use_tol(use_tol_reg), .tol(tol_reg), .lane_out(lz)
    );

    // control pipe, only the valid bits reset
    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg[0].op <= s_op;
            ctl_reg[0].dz <= (s_factor == 32'sd0);
            for (int s = 1; s <= DIV_STAGES; s++) begin
                ctl_reg[s].op <= ctl_reg[s-1].op;
                ctl_reg[s].dz <= ctl_reg[s-1].dz;
            end
        end
        if (!aresetn) begin
            for (int s = 0; s <= DIV_STAGES; s++) begin
                ctl_reg[s].valid <= 1'b0;
            end
        end else if (en) begin
            ctl_reg[0].valid <= s_valid;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                ctl_reg[s].valid <= ctl_reg[s-1].valid;
            end
        end
    end

    // merge: exact product sum for dot and squared distance, floor, saturate
    assign prod_sum = lx.prod + ly.prod + lz.prod;
    assign s_sum    = sat32(prod_sum >>> Q_SHIFT);

    always_comb begin
        rx_next = '0;
        ry_next = '0;
        rz_next = '0;
        rs_next = '0;
        eq_next = 1'b0;
        st_next = 1'b0;
        ov_next = 1'b0;
        case (ctl_reg[DIV_STAGES].op)
            OP_ADD, OP_SUB, OP_CROSS, OP_SCALE, OP_LERP: begin
                rx_next = lx.vec;
                ry_next = ly.vec;
                rz_next = lz.vec;
                ov_next = lx.vov | ly.vov | lz.vov;
            end
            OP_DIV: begin
                if (ctl_reg[DIV_STAGES].dz) begin
                    st_next = 1'b1;
                end else begin
                    rx_next = lx.vec;
                    ry_next = ly.vec;
                    rz_next = lz.vec;
                    ov_next = lx.vov | ly.vov | lz.vov;
                end
            end
            OP_DOT, OP_DIST: begin
                rs_next = s_sum.val;
                ov_next = s_sum.ov;
            end
            OP_EQUAL: eq_next = lx.eq & ly.eq & lz.eq;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= ctl_reg[DIV_STAGES].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            rz_reg <= rz_next;
            rs_reg <= rs_next;
            eq_reg <= eq_next;
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_rx       = rx_reg;
    assign m_ry       = ry_reg;
    assign m_rz       = rz_reg;
    assign m_rscalar  = rs_reg;
    assign m_is_equal = eq_reg;
    assign m_status   = st_reg;
    assign m_overflow = ov_reg;

endmodule

>>> tb/testbench.sv
// testbench for the q16.16 three-component vector alu: directed table plus random items
`timescale 1ns / 1ps

module testbench;
    import v3alu_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int N_RANDOM    = 1450;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LATENCY     = 14;

    localparam logic [2:0] ADDR_USE_TOL = 3'd0;
    localparam logic [2:0] ADDR_TOL     = 3'd4;

    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] ax, ay, az, bx, by, bz, f;
    } vec_item_t;

    typedef struct packed {
        logic [31:0] rx, ry, rz, rs;
        logic        eq, st, ov;
    } vec_result_t;

    // directed row: item plus an optional typed-in result
    typedef struct {
        vec_item_t   item;
        logic        fixed;
        vec_result_t res;
    } dir_row_t;

    logic aclk, aresetn;
    logic s_valid, s_ready;
    logic [3:0] s_opcode;
    logic signed [31:0] s_ax, s_ay, s_az, s_bx, s_by, s_bz, s_factor;
    logic m_valid, m_ready;
    logic signed [31:0] m_rx, m_ry, m_rz, m_rscalar;
    logic m_is_equal, m_status, m_overflow;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;

    vec3_fixed_point_alu_unit dut (.*);

    // predictor copy of the registers
    logic        cur_use_tol;
    logic [30:0] cur_tol;

    vec_result_t expected_q[$];
    int  mismatches;
    int  cycles;
    bit  hold_sink;   // long receiver hold-off request

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // saturate a wide value to 32 bits, flag overflow
    function automatic logic [31:0] clamp32(input logic signed [95:0] v, inout logic ov);
        if (v > 96'sh7FFF_FFFF) begin
            ov = 1'b1;
            return MAXV;
        end
        if (v < -96'sh8000_0000) begin
            ov = 1'b1;
            return MINV;
        end
        return v[31:0];
    endfunction

    function automatic vec_result_t predict_vec(input vec_item_t it);
        vec_result_t r;
        logic signed [95:0] a[3], b[3], f, acc, q;
        logic ov;
        int j, k;
        r = '{default: '0};
        ov = 1'b0;
        a[0] = $signed(it.ax); a[1] = $signed(it.ay); a[2] = $signed(it.az);
        b[0] = $signed(it.bx); b[1] = $signed(it.by); b[2] = $signed(it.bz);
        f = $signed(it.f);
        case (it.op)
            OP_ADD: begin
                r.rx = clamp32(a[0] + b[0], ov);
                r.ry = clamp32(a[1] + b[1], ov);
                r.rz = clamp32(a[2] + b[2], ov);
            end
            OP_SUB: begin
                r.rx = clamp32(a[0] - b[0], ov);
                r.ry = clamp32(a[1] - b[1], ov);
                r.rz = clamp32(a[2] - b[2], ov);
            end
            OP_DOT: begin
                acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
                r.rs = clamp32(acc >>> 16, ov);
            end
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    acc = (a[j] * b[k] - a[k] * b[j]) >>> 16;
                    if (i == 0) r.rx = clamp32(acc, ov);
                    else if (i == 1) r.ry = clamp32(acc, ov);
                    else r.rz = clamp32(acc, ov);
                end
            end
            OP_SCALE: begin
                r.rx = clamp32((a[0] * f) >>> 16, ov);
                r.ry = clamp32((a[1] * f) >>> 16, ov);
                r.rz = clamp32((a[2] * f) >>> 16, ov);
            end
            OP_DIV: begin
                if (f == 0) begin
                    r.st = 1'b1;
                end else begin
                    // signed division truncates toward zero
                    q = (a[0] * 65536) / f; r.rx = clamp32(q, ov);
                    q = (a[1] * 65536) / f; r.ry = clamp32(q, ov);
                    q = (a[2] * 65536) / f; r.rz = clamp32(q, ov);
                end
            end
            OP_LERP: begin
                r.rx = clamp32(a[0] + (((b[0] - a[0]) * f) >>> 16), ov);
                r.ry = clamp32(a[1] + (((b[1] - a[1]) * f) >>> 16), ov);
                r.rz = clamp32(a[2] + (((b[2] - a[2]) * f) >>> 16), ov);
            end
            OP_DIST: begin
                acc = (a[0] - b[0]) * (a[0] - b[0]) + (a[1] - b[1]) * (a[1] - b[1])
                    + (a[2] - b[2]) * (a[2] - b[2]);
                r.rs = clamp32(acc >>> 16, ov);
            end
            OP_EQUAL: begin
                r.eq = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    acc = (a[i] >= b[i]) ? a[i] - b[i] : b[i] - a[i];
                    if (cur_use_tol) begin
                        if (acc >= $signed({65'd0, cur_tol})) r.eq = 1'b0;
                    end else if (acc != 0) begin
                        r.eq = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        r.ov = ov;
        return r;
    endfunction

    // apb write in setup plus access cycles
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (addr == ADDR_USE_TOL) cur_use_tol = data[0];
        else cur_tol = data[30:0];
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (LATENCY + 2) @(negedge aclk);
    endtask

    // offer one item, hold until accepted
    task automatic send_item(input vec_item_t it, input int gap);
        repeat (gap) @(negedge aclk);
        s_valid = 1'b1;
        s_opcode = it.op;
        s_ax = it.ax; s_ay = it.ay; s_az = it.az;
        s_bx = it.bx; s_by = it.by; s_bz = it.bz;
        s_factor = it.f;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.push_back(predict_vec(it));
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return MAXV;
            1: return MINV;
            2: return 32'(signed'($urandom_range(0, 2000)) - 1000);
            3: return 32'(signed'($urandom_range(0, 32'h60000)) - 32'h30000);
            default: return $urandom();
        endcase
    endfunction

    function automatic vec_item_t rand_item();
        vec_item_t it;
        it.op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
        it.ax = rand_word(); it.ay = rand_word(); it.az = rand_word();
        it.bx = rand_word(); it.by = rand_word(); it.bz = rand_word();
        it.f = ($urandom_range(0, 9) == 0) ? 32'd0 : rand_word();
        // equality needs close vectors to ever be true
        if (it.op == OP_EQUAL && $urandom_range(0, 1)) begin
            it.bx = it.ax + 32'($urandom_range(0, 4)) - 32'd2;
            it.by = it.ay + 32'($urandom_range(0, 4)) - 32'd2;
            it.bz = it.az;
        end
        return it;
    endfunction

    function automatic vec_item_t mk(input logic [3:0] op, input logic [31:0] ax, ay, az,
                                     input logic [31:0] bx, by, bz, f);
        vec_item_t it;
        it.op = op; it.ax = ax; it.ay = ay; it.az = az;
        it.bx = bx; it.by = by; it.bz = bz; it.f = f;
        return it;
    endfunction

    // result checker on the output channel
    always @(posedge aclk) begin
        vec_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item got %h %h %h %h %b%b%b", m_rx, m_ry,
                             m_rz, m_rscalar, m_is_equal, m_status, m_overflow);
            end else begin
                e = expected_q.pop_front();
                if (m_rx !== e.rx || m_ry !== e.ry || m_rz !== e.rz || m_rscalar !== e.rs
                    || m_is_equal !== e.eq || m_status !== e.st || m_overflow !== e.ov) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %h %h %h %b%b%b got %h %h %h %h %b%b%b",
                                 e.rx, e.ry, e.rz, e.rs, e.eq, e.st, e.ov, m_rx, m_ry,
                                 m_rz, m_rscalar, m_is_equal, m_status, m_overflow);
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int w;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_ready = 1'b0;
                repeat (200) @(negedge aclk);
                hold_sink = 1'b0;
            end
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            if (w != 0) begin
                m_ready = 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    initial begin
        dir_row_t rows[$];
        dir_row_t row;
        int gap;
        s_valid = 0; s_opcode = 0; s_ax = 0; s_ay = 0; s_az = 0;
        s_bx = 0; s_by = 0; s_bz = 0; s_factor = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        cur_use_tol = 1'b1; cur_tol = 31'd1;
        mismatches = 0; cycles = 0; hold_sink = 0;
        aresetn = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // directed table; fixed rows carry results read straight off the spec
        row.fixed = 1'b1;
        row.item = mk(OP_ADD, MAXV, MINV, 1, 1, MINV, 0, 0);
        row.res = '{rx: MAXV, ry: MINV, rz: 1, rs: 0, eq: 0, st: 0, ov: 1};
        rows.push_back(row);
        row.item = mk(OP_SUB, MINV, MAXV, 0, 1, MINV, 0, 0);
        row.res = '{rx: MINV, ry: MAXV, rz: 0, rs: 0, eq: 0, st: 0, ov: 1};
        rows.push_back(row);
        row.item = mk(OP_DIV, 5, 6, 7, 0, 0, 0, 0);
        row.res = '{rx: 0, ry: 0, rz: 0, rs: 0, eq: 0, st: 1, ov: 0};
        rows.push_back(row);
        row.item = mk(4'd15, MAXV, MAXV, MAXV, 1, 1, 1, 1);
        row.res = '{default: '0};
        rows.push_back(row);
        row.item = mk(OP_EQUAL, 3, 3, 3, 3, 3, 3, 0);
        row.res = '{rx: 0, ry: 0, rz: 0, rs: 0, eq: 1, st: 0, ov: 0};
        rows.push_back(row);
        row.fixed = 1'b0;
        row.item = mk(OP_DOT, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0); rows.push_back(row);
        row.item = mk(OP_DOT, MINV, 1, 32'hFFFF_FFFF, 1, 1, 1, 0); rows.push_back(row);
        row.item = mk(OP_CROSS, MINV, MAXV, 7, MAXV, MINV, 32'h10000, 0); rows.push_back(row);
        row.item = mk(OP_SCALE, MINV, MAXV, 32'hFFFF_FFFF, 0, 0, 0, MINV); rows.push_back(row);
        row.item = mk(OP_SCALE, 3, 32'hFFFF_FFFD, 32'h10000, 0, 0, 0, 1); rows.push_back(row);
        row.item = mk(OP_DIV, MINV, 7, 32'hFFFF_FFF9, 0, 0, 0, 32'hFFFF_FFFF); rows.push_back(row);
        row.item = mk(OP_DIV, 7, 32'hFFFF_FFF9, 1, 0, 0, 0, 32'h30000); rows.push_back(row);
        row.item = mk(OP_LERP, MINV, MAXV, 0, MAXV, MINV, 5, MAXV); rows.push_back(row);
        row.item = mk(OP_LERP, 1, 2, 3, 9, 8, 7, 32'h8000); rows.push_back(row);
        row.item = mk(OP_DIST, MINV, MINV, MINV, MAXV, MAXV, MAXV, 0); rows.push_back(row);
        row.item = mk(OP_DIST, 0, 0, 0, 1, 32'hFFFF_FFFF, 32'h100, 0); rows.push_back(row);
        row.item = mk(OP_EQUAL, MINV, 0, 0, MAXV, 1, 0, 0); rows.push_back(row);
        foreach (rows[i]) begin
            send_item(rows[i].item, 0);
            if (rows[i].fixed) begin
                // typed-in result must agree with the predictor entry just queued
                if (expected_q[$] != rows[i].res) begin
                    mismatches++;
                    if (mismatches <= 10) $display("directed row %0d disagrees", i);
                end
            end
        end
        wait_drained();

        // register settings: exact, tolerance zero, widest tolerance, then a middle value
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin reg_write(ADDR_USE_TOL, 32'd0); reg_write(ADDR_TOL, 32'd5); end
                1: begin reg_write(ADDR_USE_TOL, 32'd1); reg_write(ADDR_TOL, 32'd0); end
                2: reg_write(ADDR_TOL, 32'hFFFF_FFFF);
                default: reg_write(ADDR_TOL, 32'd2);
            endcase
            send_item(mk(OP_EQUAL, 1, 2, 3, 2, 2, 3, 0), 0);
            send_item(mk(OP_EQUAL, MINV, 0, 0, MAXV, 0, 0, 0), 0);
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                if (phase == 1 && n == 50) hold_sink = 1'b1;
                gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
                send_item(rand_item(), gap);
                if (phase == 2 && n == 100) wait_drained();
            end
            wait_drained();
        end

        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
